// File: hw/rtl/sah_pkg.sv
// Shared types, register indexes and status codes for the sensor alarm annunciator.
package sah_pkg;

    localparam int unsigned CfgIndexWidth = 3;
    localparam int unsigned CfgDataWidth  = 16;

    localparam logic [CfgIndexWidth-1:0] REG_TEMP_LIMIT     = 3'd0;
    localparam logic [CfgIndexWidth-1:0] REG_HUMIDITY_LIMIT = 3'd1;
    localparam logic [CfgIndexWidth-1:0] REG_LIGHT_LIMIT    = 3'd2;
    localparam logic [CfgIndexWidth-1:0] REG_TEMP_HYST      = 3'd3;
    localparam logic [CfgIndexWidth-1:0] REG_HUMIDITY_HYST  = 3'd4;
    localparam logic [CfgIndexWidth-1:0] REG_LIGHT_HYST     = 3'd5;
    localparam logic [CfgIndexWidth-1:0] REG_BLINK_PERIOD   = 3'd6;
    localparam logic [CfgIndexWidth-1:0] REG_BUZZ_PERIOD    = 3'd7;

    typedef enum logic [1:0] {
        ST_NORMAL  = 2'd0,
        ST_WARNING = 2'd1,
        ST_FAULT   = 2'd2,
        ST_NODATA  = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [11:0] temp_limit;
        logic [9:0]         humidity_limit;
        logic [9:0]         light_limit;
        logic [7:0]         temp_hysteresis;
        logic [7:0]         humidity_hysteresis;
        logic [7:0]         light_hysteresis;
        logic [15:0]        blink_period;
        logic [15:0]        buzz_period;
    } cfg_t;

    typedef struct packed {
        logic [31:0]        time_ms;
        logic               data_present;
        logic               sensor_ok;
        logic signed [11:0] temperature;
        logic [9:0]         humidity;
        logic [9:0]         light_level;
    } item_t;

    typedef struct packed {
        status_t status;
        logic    red_led;
        logic    green_led;
        logic    blue_led;
        logic    buzzer_sounding;
        logic    temp_alarm_out;
        logic    humidity_alarm_out;
        logic    light_alarm_out;
    } result_t;

endpackage

// File: hw/rtl/sah_cfg_regs.sv
// Configuration register file for the sensor alarm annunciator.
module sah_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sah_pkg::CfgIndexWidth-1:0] cfg_index,
    input  logic [sah_pkg::CfgDataWidth-1:0]  cfg_data,
    output sah_pkg::cfg_t                     cfg
);
    import sah_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.temp_limit          <= 12'sd300;
            cfg_reg.humidity_limit      <= 10'd700;
            cfg_reg.light_limit         <= 10'd200;
            cfg_reg.temp_hysteresis     <= 8'd10;
            cfg_reg.humidity_hysteresis <= 8'd20;
            cfg_reg.light_hysteresis    <= 8'd20;
            cfg_reg.blink_period        <= 16'd500;
            cfg_reg.buzz_period         <= 16'd1000;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TEMP_LIMIT:     cfg_reg.temp_limit          <= $signed(cfg_data[11:0]);
                REG_HUMIDITY_LIMIT: cfg_reg.humidity_limit      <= cfg_data[9:0];
                REG_LIGHT_LIMIT:    cfg_reg.light_limit         <= cfg_data[9:0];
                REG_TEMP_HYST:      cfg_reg.temp_hysteresis     <= cfg_data[7:0];
                REG_HUMIDITY_HYST:  cfg_reg.humidity_hysteresis <= cfg_data[7:0];
                REG_LIGHT_HYST:     cfg_reg.light_hysteresis    <= cfg_data[7:0];
                REG_BLINK_PERIOD:   cfg_reg.blink_period        <= cfg_data;
                REG_BUZZ_PERIOD:    cfg_reg.buzz_period         <= cfg_data;
                default:            ;
            endcase
        end
    end

endmodule

// File: hw/rtl/sah_eval.sv
// Alarm hysteresis, status, LED blink and buzzer timing for one sensor update.
module sah_eval (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  sah_pkg::cfg_t    cfg,
    input  sah_pkg::item_t   item,
    output sah_pkg::result_t result
);
    import sah_pkg::*;

    logic        temp_alarm_reg, temp_alarm_next;
    logic        humidity_alarm_reg, humidity_alarm_next;
    logic        light_alarm_reg, light_alarm_next;
    logic        led_phase_reg, led_phase_next;
    logic [31:0] blink_start_reg, blink_start_next;
    logic        buzzer_reg, buzzer_next;
    logic [31:0] buzz_start_reg, buzz_start_next;

    logic               reading_ok;
    logic signed [12:0] temp_clear;
    logic signed [11:0] humidity_clear;
    logic [10:0]        light_clear;
    logic               temp_set, temp_clr;
    logic               humidity_set, humidity_clr;
    logic               light_set, light_clr;
    status_t            status;
    logic [31:0]        blink_elapsed;
    logic               blink_due;
    logic [31:0]        buzz_origin;
    logic [31:0]        buzz_elapsed;
    logic               red, green;

    always_comb
    begin
        reading_ok = item.data_present & item.sensor_ok;

        // clearing points are computed wider than their limits so they never wrap
        temp_clear     = $signed({cfg.temp_limit[11], cfg.temp_limit})
                         - $signed({5'b0, cfg.temp_hysteresis});
        humidity_clear = $signed({2'b0, cfg.humidity_limit})
                         - $signed({4'b0, cfg.humidity_hysteresis});
        light_clear    = {1'b0, cfg.light_limit} + {3'b0, cfg.light_hysteresis};

        temp_set     = $signed(item.temperature) >= $signed(cfg.temp_limit);
        temp_clr     = $signed({item.temperature[11], item.temperature}) <= temp_clear;
        humidity_set = item.humidity >= cfg.humidity_limit;
        humidity_clr = $signed({2'b0, item.humidity}) <= humidity_clear;
        light_set    = item.light_level <= cfg.light_limit;
        light_clr    = {1'b0, item.light_level} >= light_clear;

        temp_alarm_next     = reading_ok & (temp_alarm_reg ? !temp_clr : temp_set);
        humidity_alarm_next = reading_ok & (humidity_alarm_reg ? !humidity_clr : humidity_set);
        light_alarm_next    = reading_ok & (light_alarm_reg ? !light_clr : light_set);

        priority if (reading_ok)
            status = (temp_alarm_next | humidity_alarm_next | light_alarm_next)
                     ? ST_WARNING : ST_NORMAL;
        else if (item.data_present)
            status = ST_FAULT;
        else
            status = ST_NODATA;

        blink_elapsed = item.time_ms - blink_start_reg;
        blink_due     = blink_elapsed >= {16'b0, cfg.blink_period};

        led_phase_next   = 1'b0;
        blink_start_next = item.time_ms;
        red              = 1'b0;
        green            = 1'b0;
        unique case (status)
            ST_NORMAL:  green = 1'b1;
            ST_WARNING: red   = 1'b1;
            ST_FAULT:
            begin
                // toggle on interval expiry, otherwise hold phase and origin
                led_phase_next   = blink_due ? !led_phase_reg : led_phase_reg;
                blink_start_next = blink_due ? item.time_ms : blink_start_reg;
                red              = led_phase_next;
                green            = led_phase_next;
            end
            ST_NODATA:  ;
            default:    ;
        endcase

        // an idle buzzer restarts its interval at this update
        buzz_origin  = buzzer_reg ? buzz_start_reg : item.time_ms;
        buzz_elapsed = item.time_ms - buzz_origin;
        if (status == ST_WARNING)
        begin
            buzz_start_next = buzz_origin;
            buzzer_next     = buzz_elapsed < {16'b0, cfg.buzz_period};
        end
        else
        begin
            buzz_start_next = item.time_ms;
            buzzer_next     = 1'b0;
        end

        result.status             = status;
        result.red_led            = red;
        result.green_led          = green;
        result.blue_led           = 1'b0;
        result.buzzer_sounding    = buzzer_next;
        result.temp_alarm_out     = temp_alarm_next;
        result.humidity_alarm_out = humidity_alarm_next;
        result.light_alarm_out    = light_alarm_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_alarm_reg     <= 1'b0;
            humidity_alarm_reg <= 1'b0;
            light_alarm_reg    <= 1'b0;
            led_phase_reg      <= 1'b0;
            blink_start_reg    <= 32'd0;
            buzzer_reg         <= 1'b0;
            buzz_start_reg     <= 32'd0;
        end
        else if (advance)
        begin
            temp_alarm_reg     <= temp_alarm_next;
            humidity_alarm_reg <= humidity_alarm_next;
            light_alarm_reg    <= light_alarm_next;
            led_phase_reg      <= led_phase_next;
            blink_start_reg    <= blink_start_next;
            buzzer_reg         <= buzzer_next;
            buzz_start_reg     <= buzz_start_next;
        end
    end

endmodule

// File: hw/rtl/sensor_alarm_hysteresis_annunciator.sv
// Top level of the sensor alarm annunciator: input register, evaluation and result register.
//
//  Channel  Dir  Handshake               Carries
//  s_axis   in   s_axis_tvalid/tready    one sensor update per request
//  m_axis   out  m_axis_tvalid/tready    one status result per update
//  cfg      in   cfg_valid/cfg_ready     register index and write data
//
// An update is held in the input register and is evaluated into the result register
// when the output can take it: one update per cycle while the output is not stalled.
// Alarm, blink and buzzer state advance only when an update moves to the result
// register, so a stalled output holds everything upstream without loss.
// Reset clears alarm and timer state and loads the documented register defaults.
module sensor_alarm_hysteresis_annunciator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [31:0] time_ms, [43:32] temperature, [53:44] humidity, [63:54] light_level
    input  logic [63:0]                       s_axis_tdata,
    // [0] data_present, [1] sensor_ok
    input  logic [1:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [1:0] status, [2] red_led, [3] green_led, [4] blue_led, [5] buzzer_sounding,
    // [6] temp_alarm_out, [7] humidity_alarm_out, [8] light_alarm_out, [15:9] zero
    output logic [15:0]                       m_axis_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sah_pkg::CfgIndexWidth-1:0] cfg_index,
    input  logic [sah_pkg::CfgDataWidth-1:0]  cfg_data
);
    import sah_pkg::*;

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t result;
    result_t out_result_reg;
    logic    out_valid_reg;
    logic    advance;

    assign advance       = in_valid_reg & (!out_valid_reg | m_axis_tready);
    assign s_axis_tready = !in_valid_reg | advance;

    sah_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sah_eval u_eval (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .cfg     (cfg),
        .item    (in_item_reg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_item_reg.time_ms      <= s_axis_tdata[31:0];
            in_item_reg.temperature  <= $signed(s_axis_tdata[43:32]);
            in_item_reg.humidity     <= s_axis_tdata[53:44];
            in_item_reg.light_level  <= s_axis_tdata[63:54];
            in_item_reg.data_present <= s_axis_tuser[0];
            in_item_reg.sensor_ok    <= s_axis_tuser[1];
        end
        if (advance)
            out_result_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0,
                            out_result_reg.light_alarm_out,
                            out_result_reg.humidity_alarm_out,
                            out_result_reg.temp_alarm_out,
                            out_result_reg.buzzer_sounding,
                            out_result_reg.blue_led,
                            out_result_reg.green_led,
                            out_result_reg.red_led,
                            out_result_reg.status};

    // buzzer only sounds in warning status
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_result_reg.buzzer_sounding) |->
            (out_result_reg.status == ST_WARNING))
        else $error("buzzer on outside warning status");

    // fault and missing data clear every alarm
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_result_reg.status == ST_FAULT ||
                           out_result_reg.status == ST_NODATA)) |->
            !(out_result_reg.temp_alarm_out || out_result_reg.humidity_alarm_out ||
              out_result_reg.light_alarm_out))
        else $error("alarm held through fault or no data");

    // warning status means some alarm is set
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_result_reg.status == ST_WARNING) |->
            (out_result_reg.temp_alarm_out || out_result_reg.humidity_alarm_out ||
             out_result_reg.light_alarm_out))
        else $error("warning without alarm");

    // an evaluated request always lands in the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("evaluated request lost");

endmodule
